@@ sv/gmdw_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gmdw_pkg - shared types and constants for the grid maze walker
// Cell mark codes, request codes, turn codes, register indexes and the
// command / status types that join the controller and the datapath.
// ============================================================================
package gmdw_pkg;

    // Fixed field widths
    localparam int COORD_W    = 5;
    localparam int REQ_W      = 2;
    localparam int MARK_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Default geometry
    localparam int DEF_GRID_ROWS   = 32;
    localparam int DEF_GRID_COLS   = 32;
    localparam int DEF_STACK_DEPTH = 1024;

    // Cell marks
    localparam logic [MARK_W-1:0] MARK_FREE    = 3'd0;
    localparam logic [MARK_W-1:0] MARK_WALL    = 3'd1;
    localparam logic [MARK_W-1:0] MARK_VISITED = 3'd2;
    localparam logic [MARK_W-1:0] MARK_DEAD    = 3'd3;
    localparam logic [MARK_W-1:0] MARK_CURRENT = 3'd4;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Turn codes: the turn counter names the direction just tried
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 1'd1;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_READ,
        OP_CAPTURE,
        OP_START,
        OP_STEP,
        OP_LOOK,
        OP_POP,
        OP_EMIT
    } dp_op_t;

    // Datapath status
    typedef struct packed {
        logic start_ok;   // start cell lies inside the grid
        logic at_exit;    // top cell sits in the last column
        logic probe;      // next neighbor is inside the grid and stack has room
        logic step_left;  // turn being taken in a step is the last one
        logic look_left;  // turn held during a neighbor check is the last one
        logic nb_free;    // neighbor mark read back as free
        logic last;       // a pop empties the stack
    } dp_status_t;

endpackage

@@ sv/gmdw_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gmdw_dp - grid maze walker datapath
// Grid mark memory, search stack memory, top-of-stack registers, start
// registers and result / output registers, driven by controller commands.
// ============================================================================
module gmdw_dp #(
    parameter int GRID_ROWS   = gmdw_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS   = gmdw_pkg::DEF_GRID_COLS,
    parameter int STACK_DEPTH = gmdw_pkg::DEF_STACK_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gmdw_pkg::dp_op_t                 op,
    output gmdw_pkg::dp_status_t             status,
    input  logic [gmdw_pkg::COORD_W-1:0]     row,
    input  logic [gmdw_pkg::COORD_W-1:0]     col,
    input  logic                             cell_free,
    input  logic                             cfg_we,
    input  logic [gmdw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmdw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             found,
    output logic [gmdw_pkg::MARK_W-1:0]      cell_mark
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int AW = RW + CW;
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int EW = RW + CW + 2;

    // Storage
    logic [gmdw_pkg::MARK_W-1:0] grid_mem [0:(2**AW)-1];
    logic [EW-1:0]               stack_mem [0:STACK_DEPTH-1];

    // Control registers
    logic [PW-1:0]                    sp_reg, sp_next;
    logic [gmdw_pkg::CFG_DATA_W-1:0]  start_row_reg, start_col_reg;

    // Payload registers
    logic [RW-1:0]               top_r_reg, top_r_next, nb_r_reg, nb_r_next;
    logic [CW-1:0]               top_c_reg, top_c_next, nb_c_reg, nb_c_next;
    logic [1:0]                  top_turn_reg, top_turn_next;
    logic                        rd_ok_reg, rd_ok_next;
    logic                        found_res_reg, found_res_next;
    logic [gmdw_pkg::MARK_W-1:0] mark_res_reg, mark_res_next;
    logic                        found_out_reg, found_out_next;
    logic [gmdw_pkg::MARK_W-1:0] mark_out_reg, mark_out_next;
    logic [gmdw_pkg::MARK_W-1:0] g_rdata_reg;
    logic [EW-1:0]               s_rdata_reg;

    // Memory controls
    logic                        g_we;
    logic [AW-1:0]               g_waddr, g_raddr;
    logic [gmdw_pkg::MARK_W-1:0] g_wdata;
    logic                        s_we;
    logic [SW-1:0]               s_waddr, s_raddr;
    logic [EW-1:0]               s_wdata;

    // Derived values
    logic          in_ok, start_ok, at_exit, probe, last, nb_ok;
    logic [AW-1:0] in_addr, top_addr, nb_addr;
    logic [1:0]    turn_nx;
    logic [RW:0]   r_inc;
    logic [CW:0]   c_inc;
    logic [RW-1:0] nb_r_c;
    logic [CW-1:0] nb_c_c;

    assign in_ok    = (int'(row) < GRID_ROWS) && (int'(col) < GRID_COLS);
    assign start_ok = (int'(start_row_reg) < GRID_ROWS) && (int'(start_col_reg) < GRID_COLS);
    assign in_addr  = {RW'(row), CW'(col)};
    assign top_addr = {top_r_reg, top_c_reg};
    assign nb_addr  = {nb_r_c, nb_c_c};
    assign at_exit  = (int'(top_c_reg) == GRID_COLS - 1);
    assign last     = (sp_reg == PW'(1));
    assign turn_nx  = top_turn_reg + 2'd1;
    assign r_inc    = (RW+1)'(top_r_reg) + (RW+1)'(1);
    assign c_inc    = (CW+1)'(top_c_reg) + (CW+1)'(1);

    // Neighbor for the next turn; off-grid counts as a wall
    always_comb
    begin
        nb_r_c = top_r_reg;
        nb_c_c = top_c_reg;
        nb_ok  = 1'b0;
        case (turn_nx)
            gmdw_pkg::DIR_DOWN:
            begin
                nb_ok  = (int'(r_inc) < GRID_ROWS);
                nb_r_c = r_inc[RW-1:0];
            end
            gmdw_pkg::DIR_RIGHT:
            begin
                nb_ok  = (int'(c_inc) < GRID_COLS);
                nb_c_c = c_inc[CW-1:0];
            end
            gmdw_pkg::DIR_UP:
            begin
                nb_ok  = (top_r_reg != '0);
                nb_r_c = top_r_reg - RW'(1);
            end
            gmdw_pkg::DIR_LEFT:
            begin
                nb_ok  = (top_c_reg != '0);
                nb_c_c = top_c_reg - CW'(1);
            end
        endcase
    end

    assign probe = nb_ok && (sp_reg < PW'(STACK_DEPTH));

    assign status.start_ok  = start_ok;
    assign status.at_exit   = at_exit;
    assign status.probe     = probe;
    assign status.step_left = (turn_nx == gmdw_pkg::DIR_LEFT);
    assign status.look_left = (top_turn_reg == gmdw_pkg::DIR_LEFT);
    assign status.nb_free   = (g_rdata_reg == gmdw_pkg::MARK_FREE);
    assign status.last      = last;

    // Stack addresses: entries below the top live in memory
    assign s_raddr = SW'(sp_reg - PW'(2));
    assign s_waddr = SW'(sp_reg - PW'(1));
    assign s_wdata = {top_r_reg, top_c_reg, top_turn_reg};

    always_comb
    begin
        sp_next        = sp_reg;
        top_r_next     = top_r_reg;
        top_c_next     = top_c_reg;
        top_turn_next  = top_turn_reg;
        nb_r_next      = nb_r_reg;
        nb_c_next      = nb_c_reg;
        rd_ok_next     = rd_ok_reg;
        found_res_next = found_res_reg;
        mark_res_next  = mark_res_reg;
        found_out_next = found_out_reg;
        mark_out_next  = mark_out_reg;
        g_we           = 1'b0;
        g_waddr        = top_addr;
        g_wdata        = gmdw_pkg::MARK_CURRENT;
        g_raddr        = nb_addr;
        s_we           = 1'b0;
        unique case (op)
            gmdw_pkg::OP_NONE:
            begin
            end
            gmdw_pkg::OP_CLEAR:
            begin
                found_res_next = 1'b0;
                mark_res_next  = gmdw_pkg::MARK_FREE;
            end
            gmdw_pkg::OP_LOAD:
            begin
                found_res_next = 1'b0;
                mark_res_next  = gmdw_pkg::MARK_FREE;
                g_we           = in_ok;
                g_waddr        = in_addr;
                g_wdata        = cell_free ? gmdw_pkg::MARK_FREE : gmdw_pkg::MARK_WALL;
            end
            gmdw_pkg::OP_READ:
            begin
                found_res_next = 1'b0;
                mark_res_next  = gmdw_pkg::MARK_FREE;
                g_raddr        = in_addr;
                rd_ok_next     = in_ok;
            end
            gmdw_pkg::OP_CAPTURE:
            begin
                mark_res_next = rd_ok_reg ? g_rdata_reg : gmdw_pkg::MARK_WALL;
            end
            gmdw_pkg::OP_START:
            begin
                found_res_next = 1'b0;
                mark_res_next  = gmdw_pkg::MARK_FREE;
                top_r_next     = RW'(start_row_reg);
                top_c_next     = CW'(start_col_reg);
                top_turn_next  = gmdw_pkg::DIR_LEFT;
                sp_next        = start_ok ? PW'(1) : '0;
            end
            gmdw_pkg::OP_STEP:
            begin
                g_we = 1'b1;
                if (at_exit)
                begin
                    found_res_next = 1'b1;
                    sp_next        = '0;
                end
                else
                begin
                    top_turn_next = turn_nx;
                    nb_r_next     = nb_r_c;
                    nb_c_next     = nb_c_c;
                    // hold the cell as current while its neighbor is read
                    if (!probe && status.step_left)
                    begin
                        g_wdata = gmdw_pkg::MARK_DEAD;
                        sp_next = sp_reg - PW'(1);
                    end
                end
            end
            gmdw_pkg::OP_LOOK:
            begin
                g_we = 1'b1;
                if (status.nb_free)
                begin
                    g_wdata       = gmdw_pkg::MARK_VISITED;
                    s_we          = 1'b1;
                    top_r_next    = nb_r_reg;
                    top_c_next    = nb_c_reg;
                    top_turn_next = gmdw_pkg::DIR_LEFT;
                    sp_next       = sp_reg + PW'(1);
                end
                else if (status.look_left)
                begin
                    g_wdata = gmdw_pkg::MARK_DEAD;
                    sp_next = sp_reg - PW'(1);
                end
            end
            gmdw_pkg::OP_POP:
            begin
                {top_r_next, top_c_next, top_turn_next} = s_rdata_reg;
            end
            gmdw_pkg::OP_EMIT:
            begin
                found_out_next = found_res_reg;
                mark_out_next  = mark_res_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            start_row_reg <= gmdw_pkg::CFG_DATA_W'(1);
            start_col_reg <= gmdw_pkg::CFG_DATA_W'(1);
        end
        else
        begin
            sp_reg <= sp_next;
            if (cfg_we && (cfg_index == gmdw_pkg::CFG_START_ROW))
            begin
                start_row_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == gmdw_pkg::CFG_START_COL))
            begin
                start_col_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        top_r_reg     <= top_r_next;
        top_c_reg     <= top_c_next;
        top_turn_reg  <= top_turn_next;
        nb_r_reg      <= nb_r_next;
        nb_c_reg      <= nb_c_next;
        rd_ok_reg     <= rd_ok_next;
        found_res_reg <= found_res_next;
        mark_res_reg  <= mark_res_next;
        found_out_reg <= found_out_next;
        mark_out_reg  <= mark_out_next;
    end

    // Grid mark memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            grid_mem[g_waddr] <= g_wdata;
        end
        g_rdata_reg <= grid_mem[g_raddr];
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            stack_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= stack_mem[s_raddr];
    end

    assign found     = found_out_reg;
    assign cell_mark = mark_out_reg;

endmodule

@@ sv/gmdw_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gmdw_ctrl - grid maze walker controller
// Sequences loads, reads and the depth-first search and owns the handshake.
// ============================================================================
module gmdw_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [gmdw_pkg::REQ_W-1:0]    req_type,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  gmdw_pkg::dp_status_t          status,
    output gmdw_pkg::dp_op_t              op
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_STEP,
        S_LOOK,
        S_POP,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op             = gmdw_pkg::OP_NONE;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        gmdw_pkg::REQ_LOAD:
                        begin
                            op         = gmdw_pkg::OP_LOAD;
                            state_next = S_EMIT;
                        end
                        gmdw_pkg::REQ_SEARCH:
                        begin
                            op         = gmdw_pkg::OP_START;
                            state_next = status.start_ok ? S_STEP : S_EMIT;
                        end
                        gmdw_pkg::REQ_READ:
                        begin
                            op         = gmdw_pkg::OP_READ;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            op         = gmdw_pkg::OP_CLEAR;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                op         = gmdw_pkg::OP_CAPTURE;
                state_next = S_EMIT;
            end
            S_STEP:
            begin
                op = gmdw_pkg::OP_STEP;
                if (status.at_exit)
                begin
                    state_next = S_EMIT;
                end
                else if (status.probe)
                begin
                    state_next = S_LOOK;
                end
                else if (status.step_left)
                begin
                    state_next = status.last ? S_EMIT : S_POP;
                end
            end
            S_LOOK:
            begin
                op = gmdw_pkg::OP_LOOK;
                if (status.nb_free)
                begin
                    state_next = S_STEP;
                end
                else if (status.look_left)
                begin
                    state_next = status.last ? S_EMIT : S_POP;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_POP:
            begin
                op         = gmdw_pkg::OP_POP;
                state_next = S_STEP;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    op             = gmdw_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/grid_maze_dfs_walker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// grid_maze_dfs_walker - depth-first maze walker over a grid of cell marks
// Loads cells as free or wall, runs a stack-based depth-first walk from the
// start cell toward the last column, and reads back a cell's mark.
// ============================================================================
//
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | req_type, row, col, cell_free
//  out     | out_valid / out_stall| found, cell_mark
//  cfg     | cfg_we               | cfg_index, cfg_data (start_row, start_col)
//
// Sequence: a load or an unknown request goes from idle to the emit state,
// which sends its result once the output register can take it; a read
// goes through a read state that captures the mark before the emit state.
// A search starts in idle and ends in the emit state; each walk step runs a
// step state, a look state when the neighbor mark must be read and a pop
// state when a pop refetches the new top; the memory reads are registered.
// One word is in flight at a time; a new word is taken while the previous
// result still waits in the output register.
// Reset returns the controller to idle, empties the stack and sets the start
// cell to row 1, column 1; the grid and stack memories hold whatever they
// hold until written, so no clearing pass.
// A stalled result holds in the output register; the search does not stall.
// ============================================================================
module grid_maze_dfs_walker #(
    parameter int GRID_ROWS   = gmdw_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLS   = gmdw_pkg::DEF_GRID_COLS,
    parameter int STACK_DEPTH = gmdw_pkg::DEF_STACK_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [gmdw_pkg::REQ_W-1:0]       req_type,
    input  logic [gmdw_pkg::COORD_W-1:0]     row,
    input  logic [gmdw_pkg::COORD_W-1:0]     col,
    input  logic                             cell_free,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             found,
    output logic [gmdw_pkg::MARK_W-1:0]      cell_mark,
    // configuration
    input  logic                             cfg_we,
    input  logic [gmdw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmdw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    gmdw_pkg::dp_op_t     op;
    gmdw_pkg::dp_status_t status;

    // Controller: handshake and search sequencing
    gmdw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .op        (op)
    );

    // Datapath: memories, stack top, results
    gmdw_dp #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .row       (row),
        .col       (col),
        .cell_free (cell_free),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .found     (found),
        .cell_mark (cell_mark)
    );

endmodule

@@ sv/gmdw_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// gmdw_checker - port-level assertions for the grid maze walker
// Watches the handshake and result encoding on the top-level ports.
// ============================================================================
module gmdw_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         found,
    input logic [gmdw_pkg::MARK_W-1:0]  cell_mark
);

    // Hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(cell_mark))
        else $error("stalled result word changed");

    // A found flag and a cell mark never come from the same request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> cell_mark == gmdw_pkg::MARK_FREE)
        else $error("found set together with a cell mark");

    // Marks stay within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cell_mark <= gmdw_pkg::MARK_CURRENT)
        else $error("cell mark out of range");

    // One word at a time: an accepted word blocks the input next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while a word is in progress");

endmodule

bind grid_maze_dfs_walker gmdw_checker u_gmdw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .cell_mark (cell_mark)
);

@@ tb/sv/grid_maze_dfs_walker_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// grid_maze_dfs_walker_tb - self-checking bench for the grid maze walker
// Fills a band of rows next to the last column, fenced by walls, then runs
// short directed mazes and random rounds of carved corridors, side rooms and
// noise words inside the band. Each accepted request word is run through a
// bench-side copy of the walker, and every result word is checked field by
// field against the oldest predicted reply.
// ============================================================================
module grid_maze_dfs_walker_tb;

    localparam int ROWS  = gmdw_pkg::DEF_GRID_ROWS;
    localparam int COLS  = gmdw_pkg::DEF_GRID_COLS;
    localparam int DEPTH = gmdw_pkg::DEF_STACK_DEPTH;
    localparam int CELLS = ROWS * COLS;

    localparam int REQ_BITS  = gmdw_pkg::REQ_W;
    localparam int DATA_BITS = gmdw_pkg::CFG_DATA_W;

    // band of rows 0..BAND_ROWS-1, columns BAND_COL0..COLS-1
    localparam int BAND_ROWS = 8;
    localparam int BAND_COL0 = COLS - 12;

    // request code that the block answers with an all-zero word
    localparam logic [gmdw_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam int RANDOM_ITEMS = 270;
    localparam int LIMIT        = 1_500_000;
    // long receiver hold-off, started once the grid fill is under way
    localparam int HOLD_AT      = 100;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [gmdw_pkg::REQ_W-1:0]   kind;
        logic [gmdw_pkg::COORD_W-1:0] at_row;
        logic [gmdw_pkg::COORD_W-1:0] at_col;
        logic                         open;
    } maze_req_t;

    typedef struct packed {
        logic                        found;
        logic [gmdw_pkg::MARK_W-1:0] mark;
    } reply_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic [gmdw_pkg::REQ_W-1:0]          req_type = gmdw_pkg::REQ_LOAD;
    logic [gmdw_pkg::COORD_W-1:0]        row = '0;
    logic [gmdw_pkg::COORD_W-1:0]        col = '0;
    logic                                cell_free = 1'b0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                found;
    logic [gmdw_pkg::MARK_W-1:0]         cell_mark;
    logic                                cfg_we = 1'b0;
    logic [gmdw_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [gmdw_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // bench copy of the walker state
    logic [gmdw_pkg::MARK_W-1:0]         maze [CELLS];
    int                                  trail_pos [DEPTH];
    logic [1:0]                          trail_turn [DEPTH];
    logic [gmdw_pkg::COORD_W-1:0]        start_row_m = 5'd1;
    logic [gmdw_pkg::COORD_W-1:0]        start_col_m = 5'd1;

    maze_req_t                           req_queue [$];
    reply_t                              predicted_replies [$];

    int                                  errors = 0;
    int                                  queued = 0;
    int                                  accepted = 0;
    int                                  cycles = 0;
    int                                  gap_left = 0;
    int                                  stall_left = 0;
    int                                  hold_left = 0;
    logic                                hold_done = 1'b0;
    logic                                calm = 1'b0;

    grid_maze_dfs_walker u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .row       (row),
        .col       (col),
        .cell_free (cell_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .cell_mark (cell_mark),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Walker prediction
    // ------------------------------------------------------------------------

    // Depth-first walk from the start cell. The turn held in a stack entry
    // names the direction last tried; it advances down, right, up, left.
    // Mark the top cell current, leave it visited when a free neighbor is
    // pushed, and mark it dead when the left turn fails too.
    function automatic logic walk_maze();
        int         depth;
        int         top;
        int         p;
        int         r;
        int         c;
        int         nr;
        int         nc;
        int         np;
        logic [1:0] t;
        logic       open;
        logic       hit;
        hit = 1'b0;
        if (int'(start_row_m) >= ROWS || int'(start_col_m) >= COLS)
            return 1'b0;
        trail_pos[0]  = int'(start_row_m) * COLS + int'(start_col_m);
        trail_turn[0] = gmdw_pkg::DIR_LEFT;
        depth = 1;
        while (depth > 0)
        begin
            top = depth - 1;
            p = trail_pos[top];
            r = p / COLS;
            c = p % COLS;
            maze[p] = gmdw_pkg::MARK_CURRENT;
            if (c == COLS - 1)
            begin
                hit = 1'b1;
                break;
            end
            t = trail_turn[top] + 2'd1;
            trail_turn[top] = t;
            nr = r;
            nc = c;
            case (t)
                gmdw_pkg::DIR_DOWN:  nr = r + 1;
                gmdw_pkg::DIR_RIGHT: nc = c + 1;
                gmdw_pkg::DIR_UP:    nr = r - 1;
                default:             nc = c - 1;
            endcase
            open = 1'b0;
            // a neighbor off the grid, or one the full stack cannot take, is a wall
            if (nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS && depth < DEPTH)
            begin
                np = nr * COLS + nc;
                if (maze[np] == gmdw_pkg::MARK_FREE)
                begin
                    open = 1'b1;
                    maze[p] = gmdw_pkg::MARK_VISITED;
                    trail_pos[depth]  = np;
                    trail_turn[depth] = gmdw_pkg::DIR_LEFT;
                    depth++;
                end
            end
            if (!open && t == gmdw_pkg::DIR_LEFT)
            begin
                maze[p] = gmdw_pkg::MARK_DEAD;
                depth--;
            end
        end
        return hit;
    endfunction

    // Apply one accepted request word to the bench copy and return its reply.
    // Unused reply fields stay zero; an unknown request changes nothing.
    function automatic reply_t predict_reply(logic [gmdw_pkg::REQ_W-1:0] kind,
                                             logic [gmdw_pkg::COORD_W-1:0] r,
                                             logic [gmdw_pkg::COORD_W-1:0] c,
                                             logic f);
        reply_t rep;
        logic   on_grid;
        rep = '0;
        on_grid = (int'(r) < ROWS) && (int'(c) < COLS);
        case (kind)
            gmdw_pkg::REQ_LOAD:
                if (on_grid)
                    maze[int'(r) * COLS + int'(c)] =
                        f ? gmdw_pkg::MARK_FREE : gmdw_pkg::MARK_WALL;
            gmdw_pkg::REQ_SEARCH:
                rep.found = walk_maze();
            gmdw_pkg::REQ_READ:
                rep.mark = on_grid ? maze[int'(r) * COLS + int'(c)] : gmdw_pkg::MARK_WALL;
            default:
                rep = '0;
        endcase
        return rep;
    endfunction

    // Mostly no gap, some short ones, a few long; none during a calm stretch.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: feed words from req_queue, predict on acceptance
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        maze_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted_replies.push_back(predict_reply(req_type, row, col, cell_free));
                accepted <= accepted + 1;
            end
            // hold a stalled word as it is; otherwise idle out the gap or advance
            if (in_valid && in_stall)
                in_valid <= 1'b1;
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (req_queue.size() > 0)
            begin
                nxt = req_queue.pop_front();
                req_type  <= nxt.kind;
                row       <= nxt.at_row;
                col       <= nxt.at_col;
                cell_free <= nxt.open;
                in_valid  <= 1'b1;
                gap_left  <= pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each accepted word, then pick the next stall
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_replies
        reply_t want;
        int     burst;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("result word with no request waiting: found %0d, cell_mark %0d",
                           found, cell_mark);
                    errors++;
                end
                else
                begin
                    want = predicted_replies.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found mismatch: expected %0d, actual %0d", want.found, found);
                        errors++;
                    end
                    if (cell_mark !== want.mark)
                    begin
                        $error("cell_mark mismatch: expected %0d, actual %0d",
                               want.mark, cell_mark);
                        errors++;
                    end
                end
            end
            // a long hold-off wins over the random stalls
            if (hold_left > 0)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                burst = pick_gap();
                out_stall  <= (burst > 0);
                stall_left <= (burst > 0) ? burst - 1 : 0;
            end
        end
    end

    // Long hold-off on the result side while the grid fill keeps offering
    // words, so the block backs up and stalls its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted == HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Cycle count, calm stretches with no idling, and the run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles % 256 == 0)
            calm <= ($urandom_range(0, 3) == 0);
        if (cycles >= LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic add_req(logic [gmdw_pkg::REQ_W-1:0] kind, int r, int c, logic f);
        maze_req_t q;
        q.kind   = kind;
        q.at_row = r[gmdw_pkg::COORD_W-1:0];
        q.at_col = c[gmdw_pkg::COORD_W-1:0];
        q.open   = f;
        req_queue.push_back(q);
        queued++;
    endtask

    // Wait until every queued word has gone in and every reply has come out.
    task automatic drain();
        while (req_queue.size() != 0 || in_valid || predicted_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [gmdw_pkg::CFG_IDX_W-1:0] idx,
                             logic [gmdw_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == gmdw_pkg::CFG_START_ROW)
            start_row_m = val;
        else
            start_col_m = val;
    endtask

    task automatic finish_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int r;
        int c;
        int cc;
        int rr;
        int len;
        int roll;
        int k;
        int base;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill the band and fence it with walls below and on the left, so
        // that no read or walk ever meets an unwritten cell.
        for (r = 0; r < BAND_ROWS; r++)
            for (c = BAND_COL0; c < COLS; c++)
                add_req(gmdw_pkg::REQ_LOAD, r, c, $urandom_range(0, 9) < 6);
        for (c = BAND_COL0; c < COLS; c++)
            add_req(gmdw_pkg::REQ_LOAD, BAND_ROWS, c, 1'b0);
        for (r = 0; r < BAND_ROWS; r++)
            add_req(gmdw_pkg::REQ_LOAD, r, BAND_COL0 - 1, 1'b0);
        add_req(gmdw_pkg::REQ_READ, 0, BAND_COL0, 1'b0);
        add_req(gmdw_pkg::REQ_READ, BAND_ROWS, COLS - 1, 1'b1);
        // walk from the start cell left by reset, boxed in by walls
        add_req(gmdw_pkg::REQ_LOAD, 1, 1, 1'b1);
        add_req(gmdw_pkg::REQ_LOAD, 2, 1, 1'b0);
        add_req(gmdw_pkg::REQ_LOAD, 1, 2, 1'b0);
        add_req(gmdw_pkg::REQ_LOAD, 0, 1, 1'b0);
        add_req(gmdw_pkg::REQ_LOAD, 1, 0, 1'b0);
        add_req(gmdw_pkg::REQ_SEARCH, 0, 0, 1'b0);
        add_req(gmdw_pkg::REQ_READ, 1, 1, 1'b0);
        add_req(gmdw_pkg::REQ_READ, 0, 1, 1'b0);
        drain();

        // Start in the last column: found at once, start cell left current,
        // and still found once the start cell is a wall.
        write_reg(gmdw_pkg::CFG_START_ROW, DATA_BITS'(BAND_ROWS - 1));
        write_reg(gmdw_pkg::CFG_START_COL, DATA_BITS'(COLS - 1));
        finish_writes();
        add_req(gmdw_pkg::REQ_SEARCH, 31, 31, 1'b1);
        add_req(gmdw_pkg::REQ_READ, BAND_ROWS - 1, COLS - 1, 1'b0);
        add_req(gmdw_pkg::REQ_LOAD, BAND_ROWS - 1, COLS - 1, 1'b0);
        add_req(gmdw_pkg::REQ_SEARCH, 0, 0, 1'b0);
        add_req(gmdw_pkg::REQ_READ, BAND_ROWS - 1, COLS - 1, 1'b1);
        add_req(REQ_UNKNOWN, 31, 31, 1'b1);
        drain();

        // Start on the top edge against the left fence: walled in on every
        // side, then reopened to the right.
        write_reg(gmdw_pkg::CFG_START_ROW, DATA_BITS'(0));
        write_reg(gmdw_pkg::CFG_START_COL, DATA_BITS'(BAND_COL0));
        finish_writes();
        add_req(gmdw_pkg::REQ_LOAD, 0, BAND_COL0, 1'b0);
        add_req(gmdw_pkg::REQ_LOAD, 0, BAND_COL0 + 1, 1'b0);
        add_req(gmdw_pkg::REQ_LOAD, 1, BAND_COL0, 1'b0);
        add_req(gmdw_pkg::REQ_SEARCH, 0, 0, 1'b0);
        add_req(gmdw_pkg::REQ_READ, 0, BAND_COL0, 1'b0);
        add_req(gmdw_pkg::REQ_LOAD, 0, BAND_COL0 + 1, 1'b1);
        add_req(gmdw_pkg::REQ_LOAD, 0, BAND_COL0, 1'b1);
        add_req(gmdw_pkg::REQ_SEARCH, 31, 31, 1'b1);
        add_req(gmdw_pkg::REQ_READ, 0, BAND_COL0 + 1, 1'b0);
        add_req(gmdw_pkg::REQ_READ, 1, BAND_COL0, 1'b0);
        add_req(REQ_UNKNOWN, 0, 0, 1'b0);
        drain();

        // Random rounds: aim the start, carve a corridor to the last column,
        // sometimes open a room under it so the walk has to back out, then
        // search and read back. A few rounds keep a stale start or skip the
        // corridor, and noise words land anywhere in the band.
        base = queued;
        while (queued - base < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 9);
            len  = $urandom_range(1, COLS - BAND_COL0);
            r    = $urandom_range(0, BAND_ROWS - 1);
            c    = (roll < 2) ? $urandom_range(BAND_COL0, COLS - 1) : COLS - len;
            if (roll == 9)
            begin
                r = int'(start_row_m);
                c = int'(start_col_m);
            end
            else
            begin
                if (roll == 8)
                    r = int'(start_row_m);
                else
                    write_reg(gmdw_pkg::CFG_START_ROW, r[gmdw_pkg::CFG_DATA_W-1:0]);
                write_reg(gmdw_pkg::CFG_START_COL, c[gmdw_pkg::CFG_DATA_W-1:0]);
                finish_writes();
            end

            k = $urandom_range(0, 4);
            repeat (k)
                add_req(REQ_BITS'($urandom_range(0, 3)), $urandom_range(0, BAND_ROWS - 1),
                        $urandom_range(BAND_COL0, COLS - 1), 1'($urandom_range(0, 1)));

            if (roll >= 2)
                for (cc = c; cc < COLS; cc++)
                    add_req(gmdw_pkg::REQ_LOAD, r, cc, $urandom_range(0, 11) != 0);

            if ($urandom_range(0, 2) == 0)
                for (rr = r + 1; rr <= r + 4 && rr < BAND_ROWS; rr++)
                    for (cc = c - 2; cc <= c + 1; cc++)
                        if (cc >= BAND_COL0 && cc < COLS)
                            add_req(gmdw_pkg::REQ_LOAD, rr, cc, $urandom_range(0, 99) < 65);

            k = $urandom_range(0, 3);
            repeat (k)
                add_req(gmdw_pkg::REQ_LOAD, $urandom_range(0, BAND_ROWS - 1),
                        $urandom_range(BAND_COL0, COLS - 1), 1'b1);

            add_req(gmdw_pkg::REQ_SEARCH, $urandom_range(0, ROWS - 1),
                    $urandom_range(0, COLS - 1), 1'($urandom_range(0, 1)));

            k = $urandom_range(1, 3);
            repeat (k)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_req(gmdw_pkg::REQ_READ, r, $urandom_range(c, COLS - 1),
                            1'($urandom_range(0, 1)));
                else
                    add_req(gmdw_pkg::REQ_READ, $urandom_range(0, BAND_ROWS - 1),
                            $urandom_range(BAND_COL0, COLS - 1), 1'($urandom_range(0, 1)));
            end
            drain();
        end

        // let any stray output settle before the verdict
        repeat (16) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
sv/gmdw_pkg.sv
sv/gmdw_dp.sv
sv/gmdw_ctrl.sv
sv/grid_maze_dfs_walker.sv
sv/gmdw_checker.sv
tb/sv/grid_maze_dfs_walker_tb.sv
